// File: design/tcfp_pkg.sv
// Shared types and constants of the tuner center frequency picker.
package tcfp_pkg;

  localparam int unsigned MaxChannelsDefault = 16;
  localparam int unsigned FreqW = 32;
  localparam int unsigned RateW = 22;
  // Center arithmetic in units of 0.5 Hz, signed, with headroom above 2^33.
  localparam int unsigned CenterW = 40;
  localparam int unsigned ClearW = 15;

  localparam logic [RateW-1:0]  SpanMarginHz    = 22'd25000;
  localparam logic [ClearW-1:0] ClearHalf       = 15'd25000;
  localparam logic [RateW-1:0]  SampleRateReset = 22'd960000;
  localparam logic              AutoTuneReset   = 1'b1;

  localparam logic CfgIdxSampleRate = 1'b0;
  localparam logic CfgIdxAutoTune   = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INS_READ,
    OP_SHIFT,
    OP_PUT,
    OP_CLR_COUNT,
    OP_TRIM_INIT,
    OP_RD_HI,
    OP_CAP_HI,
    OP_CHK,
    OP_RD_HM,
    OP_DROP,
    OP_CINIT,
    OP_DIST,
    OP_NEAR,
    OP_PUSH,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic pos_one;
    logic rd_gt;
    logic last;
    logic cnt_nz;
    logic span_ok;
    logic at_hi;
  } dp_sts_t;

endpackage

// File: design/tcfp_ctrl.sv
// Controller state machine of the tuner center frequency picker.
module tcfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              auto_tune_i,
  input  tcfp_pkg::dp_sts_t sts_i,
  output tcfp_pkg::dp_cmd_t cmd_o
);
  import tcfp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_CLOSE   = 4'd4;
  localparam logic [3:0] S_T_LO    = 4'd5;
  localparam logic [3:0] S_T_CAP   = 4'd6;
  localparam logic [3:0] S_T_CHK   = 4'd7;
  localparam logic [3:0] S_T_L1    = 4'd8;
  localparam logic [3:0] S_T_DEC   = 4'd9;
  localparam logic [3:0] S_C_INIT  = 4'd10;
  localparam logic [3:0] S_W_DIST  = 4'd11;
  localparam logic [3:0] S_W_NEAR  = 4'd12;
  localparam logic [3:0] S_W_PUSH  = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.full) begin
          state_d = S_CLOSE;
        end else if (sts_i.pos_zero) begin
          cmd_o.op = OP_PUT;
          state_d  = S_CLOSE;
        end else begin
          cmd_o.op = OP_INS_READ;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.rd_gt) begin
          cmd_o.op = OP_SHIFT;
          state_d  = sts_i.pos_one ? S_INS_PUT : S_INS_CMP;
        end else begin
          cmd_o.op = OP_PUT;
          state_d  = S_CLOSE;
        end
      end
      S_INS_PUT: begin
        cmd_o.op = OP_PUT;
        state_d  = S_CLOSE;
      end
      S_CLOSE: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (auto_tune_i && sts_i.cnt_nz) begin
          cmd_o.op = OP_TRIM_INIT;
          state_d  = S_T_LO;
        end else begin
          cmd_o.op = OP_CLR_COUNT;
          state_d  = S_IDLE;
        end
      end
      S_T_LO: begin
        cmd_o.op = OP_RD_HI;
        state_d  = S_T_CAP;
      end
      S_T_CAP: begin
        cmd_o.op = OP_CAP_HI;
        state_d  = S_T_CHK;
      end
      S_T_CHK: begin
        cmd_o.op = OP_CHK;
        state_d  = sts_i.span_ok ? S_C_INIT : S_T_L1;
      end
      S_T_L1: begin
        cmd_o.op = OP_RD_HM;
        state_d  = S_T_DEC;
      end
      S_T_DEC: begin
        cmd_o.op = OP_DROP;
        state_d  = S_T_CHK;
      end
      S_C_INIT: begin
        cmd_o.op = OP_CINIT;
        state_d  = S_W_DIST;
      end
      S_W_DIST: begin
        cmd_o.op = OP_DIST;
        state_d  = S_W_NEAR;
      end
      S_W_NEAR: begin
        cmd_o.op = OP_NEAR;
        state_d  = S_W_PUSH;
      end
      S_W_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = sts_i.at_hi ? S_DONE : S_W_DIST;
      end
      S_DONE: begin
        // The finished center waits here until the output register is free.
        if (can_load) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result transaction raised outside the done state");

  a_rise_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(sts_i.last))
    else $error("result produced for an item that did not close the set");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("pending result overwritten while the output is stalled");

endmodule

// File: design/tcfp_dp.sv
// Datapath of the tuner center frequency picker: channel memory, trim and center walk.
module tcfp_dp #(
  parameter int unsigned MaxChannels = tcfp_pkg::MaxChannelsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tcfp_pkg::RateW-1:0]   sample_rate_i,
  input  logic [tcfp_pkg::FreqW-1:0]   channel_frequency_i,
  input  logic                         last_channel_i,
  input  tcfp_pkg::dp_cmd_t            cmd_i,
  output tcfp_pkg::dp_sts_t            sts_o,
  output logic [tcfp_pkg::FreqW-1:0]   center_frequency_o
);
  import tcfp_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxChannels);
  localparam int unsigned CntW  = $clog2(MaxChannels + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxChannels);

  function automatic logic [CenterW-1:0] mag(input logic [CenterW-1:0] v);
    mag = v[CenterW-1] ? (~v + CenterW'(1)) : v;
  endfunction

  logic [FreqW-1:0] mem [MaxChannels];
  logic [FreqW-1:0] rdata_q;
  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [FreqW-1:0] wr_data;

  // Control state.
  logic [CntW-1:0]  count_q, pos_q;
  logic [AddrW-1:0] lo_q, hi_q, idx_q;
  logic             last_q;

  // Working values.
  logic [FreqW-1:0]   freq_q, lo_val_q, hi_val_q, lo1_q, gap_lo_q, cur_q, nxt_q, span_q;
  logic [FreqW-1:0]   out_q;
  logic [CenterW-1:0] center_q, dist_q, absd_q;
  logic [RateW-1:0]   maxmove_q;
  logic               neg_q, push_q;

  logic [CntW-1:0]    pos_m1, pos_m2, count_m1;
  logic [AddrW-1:0]   lo_p1, hi_m1, idx_p1, idx_p2;
  logic [FreqW-1:0]   span, gap_hi, span_limit;
  logic               span_ok, drop_lo, at_hi, nearest;
  logic [CenterW-1:0] twice_cur, twice_nxt, dist_now, dist_next, center_init;
  logic [RateW-1:0]   push_amt, push_step;
  logic [FreqW-1:0]   center_sat;

  assign pos_m1   = pos_q - CntW'(1);
  assign pos_m2   = pos_q - CntW'(2);
  assign count_m1 = count_q - CntW'(1);
  assign lo_p1    = lo_q + AddrW'(1);
  assign hi_m1    = hi_q - AddrW'(1);
  assign idx_p1   = idx_q + AddrW'(1);
  assign idx_p2   = idx_q + AddrW'(2);
  assign at_hi    = (idx_q == hi_q);

  assign span       = hi_val_q - lo_val_q;
  assign span_limit = FreqW'(sample_rate_i - SpanMarginHz);
  // A sample rate below the margin leaves a negative limit that no span meets.
  assign span_ok    = (lo_q == hi_q) ||
                      ((sample_rate_i >= SpanMarginHz) && (span <= span_limit));
  assign gap_hi     = hi_val_q - rdata_q;
  assign drop_lo    = (gap_lo_q > gap_hi);

  assign twice_cur   = CenterW'({cur_q, 1'b0});
  assign twice_nxt   = CenterW'({nxt_q, 1'b0});
  assign dist_now    = twice_cur - center_q;
  assign dist_next   = twice_nxt - center_q;
  assign center_init = CenterW'(lo_val_q) + CenterW'(hi_val_q);
  assign nearest     = at_hi || (mag(dist_q) < mag(dist_next));

  // The push brings the channel out to 12500 Hz, limited by the free bandwidth.
  assign push_amt  = RateW'(ClearHalf - absd_q[ClearW-1:0]);
  assign push_step = (push_amt < maxmove_q) ? push_amt : maxmove_q;

  always_comb begin
    if (center_q[CenterW-1]) begin
      center_sat = '0;
    end else if (|center_q[CenterW-2:FreqW+1]) begin
      center_sat = '1;
    end else begin
      center_sat = center_q[FreqW:1];
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q[AddrW-1:0];
    wr_data = freq_q;
    unique case (cmd_i.op)
      OP_INS_READ: begin
        rd_en   = 1'b1;
        rd_addr = pos_m1[AddrW-1:0];
      end
      OP_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rdata_q;
        rd_en   = (pos_q != CntW'(1));
        rd_addr = pos_m2[AddrW-1:0];
      end
      OP_PUT: begin
        wr_en = 1'b1;
      end
      OP_TRIM_INIT: begin
        rd_en = 1'b1;
      end
      OP_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = hi_q;
      end
      OP_CHK: begin
        rd_en   = !span_ok;
        rd_addr = lo_p1;
      end
      OP_RD_HM: begin
        rd_en   = 1'b1;
        rd_addr = hi_m1;
      end
      OP_CINIT: begin
        rd_en   = (lo_q != hi_q);
        rd_addr = lo_p1;
      end
      OP_PUSH: begin
        rd_en   = !at_hi && (idx_p1 != hi_q);
        rd_addr = idx_p2;
      end
      OP_NONE, OP_ACCEPT, OP_CLR_COUNT, OP_CAP_HI, OP_DROP, OP_DIST, OP_NEAR, OP_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_ACCEPT: begin
          pos_q  <= count_q;
          last_q <= last_channel_i;
        end
        OP_SHIFT:     pos_q   <= pos_m1;
        OP_PUT:       count_q <= count_q + CntW'(1);
        OP_CLR_COUNT: count_q <= '0;
        OP_OUT:       count_q <= '0;
        OP_TRIM_INIT: begin
          lo_q <= '0;
          hi_q <= count_m1[AddrW-1:0];
        end
        OP_DROP: begin
          if (drop_lo) begin
            lo_q <= lo_p1;
          end else begin
            hi_q <= hi_m1;
          end
        end
        OP_CINIT: idx_q <= lo_q;
        OP_PUSH: begin
          if (!at_hi) begin
            idx_q <= idx_p1;
          end
        end
        OP_NONE, OP_INS_READ, OP_RD_HI, OP_CAP_HI, OP_CHK, OP_RD_HM, OP_DIST, OP_NEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: freq_q   <= channel_frequency_i;
      OP_RD_HI:  lo_val_q <= rdata_q;
      OP_CAP_HI: hi_val_q <= rdata_q;
      OP_CHK:    span_q   <= span;
      OP_RD_HM: begin
        lo1_q    <= rdata_q;
        gap_lo_q <= rdata_q - lo_val_q;
      end
      OP_DROP: begin
        if (drop_lo) begin
          lo_val_q <= lo1_q;
        end else begin
          hi_val_q <= rdata_q;
        end
      end
      OP_CINIT: begin
        center_q  <= center_init;
        maxmove_q <= sample_rate_i - span_q[RateW-1:0];
        cur_q     <= lo_val_q;
      end
      OP_DIST: begin
        dist_q <= dist_now;
        nxt_q  <= rdata_q;
      end
      OP_NEAR: begin
        absd_q <= mag(dist_q);
        neg_q  <= dist_q[CenterW-1];
        push_q <= nearest && (mag(dist_q) < CenterW'(ClearHalf));
      end
      OP_PUSH: begin
        if (push_q) begin
          if (neg_q) begin
            center_q <= center_q + CenterW'(push_step);
          end else begin
            center_q <= center_q - CenterW'(push_step);
          end
        end
        if (!at_hi) begin
          cur_q <= nxt_q;
        end
      end
      OP_OUT: out_q <= center_sat;
      OP_NONE, OP_INS_READ, OP_SHIFT, OP_PUT, OP_CLR_COUNT, OP_TRIM_INIT: begin
      end
      default: begin
      end
    endcase
  end

  assign sts_o.full     = (count_q >= CntMax);
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.pos_one  = (pos_q == CntW'(1));
  assign sts_o.rd_gt    = (rdata_q > freq_q);
  assign sts_o.last     = last_q;
  assign sts_o.cnt_nz   = (count_q != '0);
  assign sts_o.span_ok  = span_ok;
  assign sts_o.at_hi    = at_hi;

  assign center_frequency_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("channel count beyond the store depth");

  a_lo_not_above_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("trim window inverted");

  a_out_needs_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |-> (count_q != '0))
    else $error("center produced from an empty channel set");

endmodule

// File: design/tuner_center_frequency_picker.sv
// Tuner center frequency picker: takes channel frequencies one transaction at a time, keeps
// them sorted in a channel memory, and after the transaction marked last_channel
// (with auto-tune on) trims the set to the sample rate and returns one center frequency.
// Every memory read goes through the one read port with a registered output, beside a single
// write port, which sets the timing: an item into an empty or a full store needs no moves,
// any other item moves k stored channels up to make room (up to MAX_CHANNELS - 1). A closing
// item then adds the trim, which drops d channels, the center walk over the n channels left
// and the wait for the output register. A new item is taken as soon as the previous one is
// done, even while a result still waits on the output. There is no clearing pass after reset.
module tuner_center_frequency_picker #(
  parameter int unsigned MAX_CHANNELS = tcfp_pkg::MaxChannelsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [tcfp_pkg::RateW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tcfp_pkg::FreqW-1:0] channel_frequency_i,
  input  logic                       last_channel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcfp_pkg::FreqW-1:0] center_frequency_o
);
  import tcfp_pkg::*;

  logic [RateW-1:0] sample_rate_q;
  logic             auto_tune_q;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SampleRateReset;
      auto_tune_q   <= AutoTuneReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgIdxSampleRate: sample_rate_q <= cfg_wdata_i;
        CfgIdxAutoTune:   auto_tune_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  tcfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .auto_tune_i (auto_tune_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcfp_dp #(
    .MaxChannels (MAX_CHANNELS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_rate_i       (sample_rate_q),
    .channel_frequency_i (channel_frequency_i),
    .last_channel_i      (last_channel_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .center_frequency_o  (center_frequency_o)
  );

endmodule
